>>> rtl/core/swsm_pkg.sv
package swsm_pkg;

   // request codes on the input channel
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_HALF_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TURNAROUND  = 1'b1;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd1;
   localparam logic [15:0] TURNAROUND_RESET  = 16'd75;

   // bits shifted out for a write (address and data) and for a read (address)
   localparam logic [4:0] WRITE_BITS = 5'd16;
   localparam logic [4:0] READ_BITS  = 5'd8;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] address;
      logic [7:0] wdata;
      logic       sda_in;
   } swsm_req_type;

   typedef struct packed {
      logic       sck;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic [7:0] rdata;
      logic       rdata_valid;
      logic       write_done;
   } swsm_rsp_type;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NOP   = 2'd3
   } swsm_kind_type;

   typedef struct packed {
      swsm_kind_type kind;
      logic [7:0]    address;
      logic [7:0]    wdata;
      logic          sda_in;
   } swsm_item_type;

   typedef struct packed {
      logic [15:0] half_period_ticks;
      logic [15:0] turnaround_ticks;
   } swsm_cfg_type;

endpackage

>>> rtl/core/sensor_two_wire_serial_master.sv
// Two-wire sensor port master (clock line plus one shared data line).
//
// req channel: one transaction per item. req_type selects a tick, a write
// (address then data byte, MSB first) or a read (address out, eight bits in).
// Ticks advance the bit timing; sda_in carries the data line level for that
// tick. Reads and writes during a transfer are ignored, as is code 3.
// rsp channel: exactly one transaction per accepted request, in order, with
// the line levels after that item and the completion pulses.
// csr channel: write half_period_ticks (index 0) or turnaround_ticks
// (index 1); always ready. The user must write only while the block is idle;
// the block itself does not enforce this.
// Throughput is one item per cycle while rsp is not stalled: the classifier
// pushes into a small queue and the line engine retires one queued item
// per cycle into the output register. An accepted req is written into the
// queue, then popped into the output register, which raises rsp_valid.
// When the receiver stalls rsp, the engine holds and the queue fills; once
// it is full req_ready drops. Reset empties the queue, clears rsp_valid
// and returns the engine to idle with both lines low and released;
// the registers return to a half period of 1 and a turnaround of 75 ticks.
module sensor_two_wire_serial_master #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  swsm_pkg::swsm_req_type                   req_data,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output swsm_pkg::swsm_rsp_type                   rsp_data,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [swsm_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [15:0]                              csr_data
);
   import swsm_pkg::*;

   swsm_cfg_type  cfg_ff, cfg_in;
   swsm_item_type push_item;
   swsm_item_type head_item;
   logic          q_full;
   logic          q_push;
   logic          q_not_empty;
   logic          q_pop;

   // configuration registers: take every write at once
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_PERIOD: cfg_in.half_period_ticks = csr_data;
            CSR_TURNAROUND:  cfg_in.turnaround_ticks  = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period_ticks <= HALF_PERIOD_RESET;
         cfg_ff.turnaround_ticks  <= TURNAROUND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   swsm_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_item    (push_item)
   );

   // decouple the front from the line engine
   swsm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop       (q_pop),
      .head_item (head_item)
   );

   // back: run the bit timing and drive the output register
   swsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_item      (head_item),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

`ifndef ASSERT_OFF
   // rdata is zero unless a read completes
   a_rdata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.rdata_valid |-> rsp_data.rdata == 8'd0)
      else $error("rdata nonzero without rdata_valid");

   // a completion pulse always leaves the engine idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.rdata_valid || rsp_data.write_done) |-> !rsp_data.busy_res)
      else $error("completion reported while still busy");

   // a read completes with the data line released
   a_read_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rdata_valid |-> !rsp_data.sda_drive && rsp_data.sck)
      else $error("read completed with data line driven or clock low");

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");
`endif

endmodule

>>> rtl/core/swsm_front.sv
module swsm_front (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  swsm_pkg::swsm_req_type req_data,
   input  logic                   q_full,
   output logic                   q_push,
   output swsm_pkg::swsm_item_type q_item
);
   import swsm_pkg::*;

   swsm_kind_type kind;

   // classify the request code; code 3 becomes a no-op
   always_comb begin
      unique case (req_data.req_type)
         REQ_TICK:  kind = KIND_TICK;
         REQ_WRITE: kind = KIND_WRITE;
         REQ_READ:  kind = KIND_READ;
         default:   kind = KIND_NOP;
      endcase
   end

   assign req_ready       = !q_full;
   assign q_push          = req_valid && !q_full;
   assign q_item.kind     = kind;
   assign q_item.address  = req_data.address;
   assign q_item.wdata    = req_data.wdata;
   assign q_item.sda_in   = req_data.sda_in;

endmodule

>>> rtl/core/swsm_queue.sv
module swsm_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  swsm_pkg::swsm_item_type push_item,
   output logic                    full,
   output logic                    not_empty,
   input  logic                    pop,
   output swsm_pkg::swsm_item_type head_item
);
   import swsm_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   swsm_item_type    entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/swsm_back.sv
module swsm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  swsm_pkg::swsm_cfg_type  cfg,
   input  logic                    q_not_empty,
   input  swsm_pkg::swsm_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output swsm_pkg::swsm_rsp_type  rsp_data
);
   import swsm_pkg::*;

   typedef enum logic [7:0] {
      PH_IDLE    = 8'b0000_0001,
      PH_WLOW    = 8'b0000_0010,
      PH_WHIGH   = 8'b0000_0100,
      PH_RLOW_A  = 8'b0000_1000,
      PH_RHIGH_A = 8'b0001_0000,
      PH_TURN    = 8'b0010_0000,
      PH_INLOW   = 8'b0100_0000,
      PH_INHIGH  = 8'b1000_0000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] out_shift_ff, out_shift_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [15:0] tick_count_ff, tick_count_in;
   logic [7:0]  in_shift_ff, in_shift_in;
   logic        sck_ff, sck_in;
   logic        sda_lvl_ff, sda_lvl_in;
   logic        drive_ff, drive_in;
   logic        rsp_valid_ff, rsp_valid_in;
   swsm_rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0] half;
   logic [15:0] tick_inc;
   logic [15:0] start_shift;
   logic [4:0]  start_count;
   logic [4:0]  in_count_dec;
   logic        half_done;
   logic        turn_done;
   logic        rvalid;
   logic        wdone;

   assign half         = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
   assign tick_inc     = tick_count_ff + 16'd1;
   assign half_done    = (tick_inc >= half);
   assign turn_done    = (tick_inc >= cfg.turnaround_ticks);
   assign in_count_dec = bit_count_ff - 5'd1;
   assign start_shift  = (q_item.kind == KIND_WRITE) ? {q_item.address, q_item.wdata}
                                                     : {q_item.address, 8'd0};
   assign start_count  = (q_item.kind == KIND_WRITE) ? WRITE_BITS : READ_BITS;

   // take the next item whenever the output register is free or draining
   assign q_pop = q_not_empty && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      phase_in      = phase_ff;
      out_shift_in  = out_shift_ff;
      bit_count_in  = bit_count_ff;
      tick_count_in = tick_count_ff;
      in_shift_in   = in_shift_ff;
      sck_in        = sck_ff;
      sda_lvl_in    = sda_lvl_ff;
      drive_in      = drive_ff;
      rvalid        = 1'b0;
      wdone         = 1'b0;

      if (phase_ff == PH_IDLE &&
          (q_item.kind == KIND_WRITE || q_item.kind == KIND_READ)) begin
         // start: put the first address bit on the line
         phase_in      = (q_item.kind == KIND_WRITE) ? PH_WLOW : PH_RLOW_A;
         sck_in        = 1'b0;
         drive_in      = 1'b1;
         sda_lvl_in    = start_shift[15];
         out_shift_in  = {start_shift[14:0], 1'b0};
         bit_count_in  = start_count - 5'd1;
         tick_count_in = '0;
      end else if (q_item.kind == KIND_TICK && phase_ff != PH_IDLE) begin
         tick_count_in = tick_inc;
         unique case (phase_ff)
            PH_WLOW, PH_RLOW_A: begin
               if (half_done) begin
                  phase_in      = (phase_ff == PH_WLOW) ? PH_WHIGH : PH_RHIGH_A;
                  sck_in        = 1'b1;
                  tick_count_in = '0;
               end
            end
            PH_WHIGH, PH_RHIGH_A: begin
               if (half_done) begin
                  tick_count_in = '0;
                  if (bit_count_ff != '0) begin
                     phase_in     = (phase_ff == PH_RHIGH_A) ? PH_RLOW_A : PH_WLOW;
                     sck_in       = 1'b0;
                     drive_in     = 1'b1;
                     sda_lvl_in   = out_shift_ff[15];
                     out_shift_in = {out_shift_ff[14:0], 1'b0};
                     bit_count_in = bit_count_ff - 5'd1;
                  end else begin
                     phase_in = PH_TURN;
                     if (phase_ff == PH_RHIGH_A) begin
                        // release the data line for the sensor
                        drive_in   = 1'b0;
                        sda_lvl_in = 1'b0;
                     end
                     if (cfg.turnaround_ticks == '0) begin
                        if (phase_ff == PH_RHIGH_A) begin
                           phase_in     = PH_INLOW;
                           sck_in       = 1'b0;
                           bit_count_in = READ_BITS;
                           in_shift_in  = '0;
                        end else begin
                           phase_in = PH_IDLE;
                           wdone    = 1'b1;
                        end
                     end
                  end
               end
            end
            PH_TURN: begin
               if (turn_done) begin
                  tick_count_in = '0;
                  if (!drive_ff) begin
                     phase_in     = PH_INLOW;
                     sck_in       = 1'b0;
                     bit_count_in = READ_BITS;
                     in_shift_in  = '0;
                  end else begin
                     phase_in = PH_IDLE;
                     wdone    = 1'b1;
                  end
               end
            end
            PH_INLOW: begin
               if (half_done) begin
                  phase_in      = PH_INHIGH;
                  sck_in        = 1'b1;
                  tick_count_in = '0;
               end
            end
            PH_INHIGH: begin
               if (half_done) begin
                  // sample at the end of the high phase
                  in_shift_in   = {in_shift_ff[6:0], q_item.sda_in};
                  bit_count_in  = in_count_dec;
                  tick_count_in = '0;
                  if (in_count_dec == '0) begin
                     phase_in = PH_IDLE;
                     rvalid   = 1'b1;
                  end else begin
                     phase_in = PH_INLOW;
                     sck_in   = 1'b0;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_data_in.sck         = sck_in;
      rsp_data_in.sda_out     = sda_lvl_in;
      rsp_data_in.sda_drive   = drive_in;
      rsp_data_in.busy_res    = (phase_in != PH_IDLE);
      rsp_data_in.rdata       = rvalid ? in_shift_in : 8'd0;
      rsp_data_in.rdata_valid = rvalid;
      rsp_data_in.write_done  = wdone;
      rsp_valid_in            = q_pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         out_shift_ff  <= '0;
         bit_count_ff  <= '0;
         tick_count_ff <= '0;
         in_shift_ff   <= '0;
         sck_ff        <= 1'b0;
         sda_lvl_ff    <= 1'b0;
         drive_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            phase_ff      <= phase_in;
            out_shift_ff  <= out_shift_in;
            bit_count_ff  <= bit_count_in;
            tick_count_ff <= tick_count_in;
            in_shift_ff   <= in_shift_in;
            sck_ff        <= sck_in;
            sda_lvl_ff    <= sda_lvl_in;
            drive_ff      <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
